// ----- rtl/circle_mask_rect_generator_unit_macros.svh -----
// Assertion macros used by the circle mask rectangle generator top level
`ifndef CIRCLE_MASK_RECT_GENERATOR_UNIT_MACROS_SVH
`define CIRCLE_MASK_RECT_GENERATOR_UNIT_MACROS_SVH

// Check cons in the same cycle as ante.
`define CMRU_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define CMRU_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cmru_pkg.sv -----
// Shared types, widths and constants of the circle mask rectangle generator
package cmru_pkg;

  localparam int ROW_W      = 8;
  localparam int X_W        = 9;
  localparam int Y_W        = 8;
  localparam int CX_W       = 14;
  localparam int R_W        = 12;
  localparam int COORD_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam int MA_W     = R_W;
  localparam int MB_W     = R_W + 1;
  localparam int PROD_W   = MA_W + MB_W;
  localparam int SQ_IN_W  = 2 * R_W;
  localparam int SQ_RES_W = SQ_IN_W / 2;
  localparam int H_W      = SQ_RES_W + 1;

  localparam int BUF_DEPTH = 4;
  localparam int BUF_IDX_W = $clog2(BUF_DEPTH);
  localparam int BUF_CNT_W = $clog2(BUF_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = CFG_IDX_W'(2);

  localparam logic signed [CX_W-1:0] CENTER_X_RST = 14'sd2048;
  localparam logic signed [CX_W-1:0] CENTER_Y_RST = 14'sd1920;
  localparam logic [R_W-1:0]         RADIUS_RST   = 12'd2968;

  typedef struct packed {
    logic [X_W-1:0] x_left;
    logic [Y_W-1:0] y_top;
    logic [X_W-1:0] x_right;
    logic [Y_W-1:0] y_bottom;
  } cmru_rect_t;

  typedef struct packed {
    logic       push;
    cmru_rect_t rect;
    logic       drain;
  } cmru_buf_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_BAND_T,
    S_BAND_B,
    S_MUL,
    S_SQRT,
    S_EDGE,
    S_FLUSH_L,
    S_FLUSH_R,
    S_END,
    S_DRAIN
  } cmru_state_t;

endpackage

// ----- rtl/cmru_channels.sv -----
// Handshake channel interfaces: row input, rectangle output, register write
interface cmru_row_if;
  logic                         valid;
  logic                         ready;
  logic [cmru_pkg::ROW_W-1:0]   row;
  modport source (output valid, output row, input ready);
  modport sink   (input valid, input row, output ready);
endinterface

interface cmru_rect_if;
  logic                       valid;
  logic                       ready;
  logic [cmru_pkg::X_W-1:0]   x_left;
  logic [cmru_pkg::Y_W-1:0]   y_top;
  logic [cmru_pkg::X_W-1:0]   x_right;
  logic [cmru_pkg::Y_W-1:0]   y_bottom;
  logic                       last_of_batch;
  modport source (output valid, output x_left, output y_top, output x_right,
                  output y_bottom, output last_of_batch, input ready);
  modport sink   (input valid, input x_left, input y_top, input x_right,
                  input y_bottom, input last_of_batch, output ready);
endinterface

interface cmru_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [cmru_pkg::CFG_IDX_W-1:0]    index;
  logic [cmru_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/cmru_ser_mult.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle
module cmru_ser_mult (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [cmru_pkg::MA_W-1:0]     a,
  input  logic [cmru_pkg::MB_W-1:0]     b,
  output logic                          done,
  output logic [cmru_pkg::PROD_W-1:0]   prod
);

  localparam int MA_W  = cmru_pkg::MA_W;
  localparam int MB_W  = cmru_pkg::MB_W;
  localparam int CNT_W = $clog2(MA_W + 1);

  logic [cmru_pkg::PROD_W-1:0] p_r, p_nxt;
  logic [MB_W-1:0]             b_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        done_r;
  logic [MB_W:0]               sum;

  // Add the multiplicand into the high half when the low bit is set, then
  // shift the partial product right by one.
  assign sum   = {1'b0, p_r[cmru_pkg::PROD_W-1:MA_W]} + (p_r[0] ? {1'b0, b_r} : '0);
  assign p_nxt = {sum, p_r[MA_W-1:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(MA_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= {{MB_W{1'b0}}, a};
      b_r <= b;
    end else if (cnt_r != '0) begin
      p_r <= p_nxt;
    end
  end

  assign done = done_r;
  assign prod = p_r;

endmodule

// ----- rtl/cmru_ser_sqrt.sv -----
// Digit-serial ceiling square root, one result bit per cycle
module cmru_ser_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [cmru_pkg::SQ_IN_W-1:0]   v,
  output logic                           done,
  output logic [cmru_pkg::H_W-1:0]       h
);

  localparam int IN_W  = cmru_pkg::SQ_IN_W;
  localparam int RES_W = cmru_pkg::SQ_RES_W;
  localparam int REM_W = RES_W + 1;
  localparam int SH_W  = RES_W + 3;
  localparam int CNT_W = $clog2(RES_W + 1);

  logic [IN_W-1:0]  v_r;
  logic [RES_W-1:0] root_r;
  logic [REM_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;
  logic [SH_W-1:0]  rem_sh, trial;
  logic             ge;

  // Bring down the next radicand digit pair and try root*4+1.
  assign rem_sh = {rem_r, v_r[IN_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_W'(1));
      if (start) begin
        cnt_r <= CNT_W'(RES_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= v;
      root_r <= '0;
      rem_r  <= '0;
    end else if (cnt_r != '0) begin
      v_r    <= {v_r[IN_W-3:0], 2'b00};
      root_r <= {root_r[RES_W-2:0], ge};
      rem_r  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
    end
  end

  // A nonzero remainder means the exact root lies above the floor root.
  assign h    = {1'b0, root_r} + cmru_pkg::H_W'(rem_r != '0);
  assign done = done_r;

endmodule

// ----- rtl/cmru_rect_buf.sv -----
// Four-entry rectangle buffer with the registered output stage
module cmru_rect_buf (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmru_pkg::cmru_buf_ctl_t ctl,
  output logic                    empty,
  cmru_rect_if.source             out_ch
);

  localparam int IDX_W = cmru_pkg::BUF_IDX_W;
  localparam int CNT_W = cmru_pkg::BUF_CNT_W;

  cmru_pkg::cmru_rect_t ent_r [cmru_pkg::BUF_DEPTH];
  cmru_pkg::cmru_rect_t rect_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     rd_r;
  logic                 valid_r;
  logic                 last_r;
  logic                 load;
  logic                 is_last;

  assign load    = ctl.drain && (cnt_r != '0) && (!valid_r || out_ch.ready);
  assign is_last = ({1'b0, rd_r} == (cnt_r - CNT_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      if (ctl.push) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (load && is_last) begin
        cnt_r <= '0;
      end
      if (load) begin
        rd_r <= is_last ? '0 : rd_r + IDX_W'(1);
      end
      if (load) begin
        valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      ent_r[cnt_r[IDX_W-1:0]] <= ctl.rect;
    end
    if (load) begin
      rect_r <= ent_r[rd_r];
      last_r <= is_last;
    end
  end

  assign empty                = (cnt_r == '0);
  assign out_ch.valid         = valid_r;
  assign out_ch.x_left        = rect_r.x_left;
  assign out_ch.y_top         = rect_r.y_top;
  assign out_ch.x_right       = rect_r.x_right;
  assign out_ch.y_bottom      = rect_r.y_bottom;
  assign out_ch.last_of_batch = last_r;

endmodule

// ----- rtl/circle_mask_rect_generator_unit.sv -----
// Top level: scanline sequencer that emits the rectangles masking outside a circle
//
//  channel  | dir | payload                                      | accepted when
//  ---------+-----+----------------------------------------------+------------------
//  in_ch    | in  | row                                          | valid & ready
//  out_ch   | out | x_left y_top x_right y_bottom last_of_batch  | valid & ready
//  cfg_ch   | in  | index (0 center_x, 1 center_y, 2 radius) data| valid & ready
//
// A row outside the circle skips the arithmetic; a row inside it runs through
// the 12-step serial multiplier and square root, then flushes any broken run.
// Reset (rst_n low, synchronous) drops any open run and loads the register
// defaults. The next row is taken once the last rectangle of this one sits in
// the output register; a stall at the sink holds off the drain.
`include "circle_mask_rect_generator_unit_macros.svh"

module circle_mask_rect_generator_unit #(
  parameter int SCREEN_WIDTH   = 256,
  parameter int SCREEN_HEIGHT  = 240,
  parameter int OPEN_RADIUS_Q4 = 2968
) (
  input  logic         clk,
  input  logic         rst_n,
  cmru_row_if.sink     in_ch,
  cmru_rect_if.source  out_ch,
  cmru_cfg_if.sink     cfg_ch
);

  localparam int CW   = cmru_pkg::COORD_W;
  localparam int R_W  = cmru_pkg::R_W;
  localparam int CX_W = cmru_pkg::CX_W;
  localparam int H_W  = cmru_pkg::H_W;

  localparam logic [CW-1:0]  SCR_W  = CW'(SCREEN_WIDTH);
  localparam logic [CW-1:0]  SCR_H  = CW'(SCREEN_HEIGHT);
  localparam logic [R_W-1:0] OPEN_R = R_W'(OPEN_RADIUS_Q4);

  // Clamp a signed pixel coordinate into [0, hi].
  function automatic logic [CW-1:0] clamp_c(logic signed [14:0] v, logic [CW-1:0] hi);
    logic [CW-1:0] res;
    if (v < 15'sd0) begin
      res = '0;
    end else if (v > $signed(15'(hi))) begin
      res = hi;
    end else begin
      res = v[CW-1:0];
    end
    return res;
  endfunction

  function automatic cmru_pkg::cmru_rect_t mk_rect(logic [CW-1:0] xl, logic [CW-1:0] yt,
                                                   logic [CW-1:0] xr, logic [CW-1:0] yb);
    cmru_pkg::cmru_rect_t r;
    r.x_left   = xl[cmru_pkg::X_W-1:0];
    r.y_top    = yt[cmru_pkg::Y_W-1:0];
    r.x_right  = xr[cmru_pkg::X_W-1:0];
    r.y_bottom = yb[cmru_pkg::Y_W-1:0];
    return r;
  endfunction

  cmru_pkg::cmru_state_t state_r, state_nxt;

  // Configuration registers
  logic signed [CX_W-1:0] cx_r, cy_r;
  logic [R_W-1:0]         rad_r;

  // Per-row working registers
  logic [cmru_pkg::ROW_W-1:0] row_r;
  logic [CW-1:0]              top_r, bot_r;
  logic                       inrng_r;
  logic [H_W-1:0]             h_r;
  logic [CW-1:0]              new_l_r, new_r_r;
  logic                       fin_r;

  // Open run
  logic                       run_open_r;
  logic [cmru_pkg::ROW_W-1:0] run_start_r;
  logic [8:0]                 run_rows_r;
  logic [CW-1:0]              run_left_r, run_right_r;

  logic                       row0, rad_open, rad_zero;
  logic signed [14:0]         cx_ext, cy_ext, rad_ext, h_ext;
  logic signed [14:0]         band_lo, band_hi, edge_lo, edge_hi;
  logic [CW-1:0]              top_c, bot_c, lx_c, rx_c, row_c, fbot;
  logic                       inrng_c, match_c, is_last_row;
  logic signed [15:0]         dy_c, dy_abs;
  logic [R_W:0]               d_c;
  logic signed [R_W+1:0]      a_diff;
  logic [cmru_pkg::MA_W-1:0]  ma;
  logic [cmru_pkg::MB_W-1:0]  mb;
  logic [9:0]                 bsum;

  logic                        in_acc;
  logic                        mul_start, mul_done, sq_done;
  logic [cmru_pkg::PROD_W-1:0] mul_p;
  logic [H_W-1:0]              sq_h;
  cmru_pkg::cmru_buf_ctl_t     ctl;
  logic                        buf_empty;

  assign in_acc = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Row geometry
  // --------------------------------------------------------------------------
  assign row0     = (row_r == '0);
  assign rad_open = (rad_r >= OPEN_R);
  assign rad_zero = (rad_r == '0);
  assign row_c    = CW'(row_r);

  assign cx_ext  = $signed({cx_r[CX_W-1], cx_r});
  assign cy_ext  = $signed({cy_r[CX_W-1], cy_r});
  assign rad_ext = $signed({3'b000, rad_r});
  assign h_ext   = $signed({2'b00, h_r});

  // Band limits: floor of the top, ceiling of the bottom, in whole rows.
  assign band_lo = (cy_ext - rad_ext) >>> 4;
  assign band_hi = (cy_ext + rad_ext + 15'sd15) >>> 4;
  assign top_c   = clamp_c(band_lo, SCR_H);
  assign bot_c   = clamp_c(band_hi, SCR_H);
  assign inrng_c = (row_c >= top_c) && (row_c < bot_c);

  // Distance from the row center to the circle center. Inside the band it
  // stays within radius + 7, so one bit above the radius width holds it.
  assign dy_c   = $signed({4'b0000, row_r, 4'b1000}) - $signed({{2{cy_r[CX_W-1]}}, cy_r});
  assign dy_abs = dy_c[15] ? -dy_c : dy_c;
  assign d_c    = dy_abs[R_W:0];

  // r^2 - dy^2 as (r - dy)(r + dy); a negative first factor means zero width,
  // and then the second factor no longer matters.
  assign a_diff = $signed({2'b00, rad_r}) - $signed({1'b0, d_c});
  assign ma     = a_diff[R_W+1] ? '0 : a_diff[R_W-1:0];
  assign mb     = cmru_pkg::MB_W'({1'b0, rad_r} + d_c);

  // Row edges from the half-width.
  assign edge_lo = (cx_ext - h_ext) >>> 4;
  assign edge_hi = (cx_ext + h_ext + 15'sd15) >>> 4;
  assign lx_c    = clamp_c(edge_lo, SCR_W);
  assign rx_c    = clamp_c(edge_hi, SCR_W);
  assign match_c = run_open_r && (lx_c == run_left_r) && (rx_c == run_right_r);

  // Bottom of the open run, held to the screen.
  assign bsum        = {2'b00, run_start_r} + {1'b0, run_rows_r};
  assign fbot        = ({1'b0, bsum} > SCR_H) ? SCR_H : CW'(bsum);
  assign is_last_row = (row_c == bot_r - CW'(1));

  // --------------------------------------------------------------------------
  // Serial arithmetic
  // --------------------------------------------------------------------------
  cmru_ser_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (ma),
    .b     (mb),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // The product is at most r^2, so its top bit is always clear.
  cmru_ser_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_done),
    .v     (mul_p[cmru_pkg::SQ_IN_W-1:0]),
    .done  (sq_done),
    .h     (sq_h)
  );

  cmru_rect_buf u_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .empty  (buf_empty),
    .out_ch (out_ch)
  );

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cmru_pkg::S_IDLE: begin
        if (in_ch.valid) state_nxt = cmru_pkg::S_SETUP;
      end
      cmru_pkg::S_SETUP: begin
        if (rad_open || rad_zero) state_nxt = cmru_pkg::S_DRAIN;
        else                      state_nxt = cmru_pkg::S_BAND_T;
      end
      cmru_pkg::S_BAND_T: state_nxt = cmru_pkg::S_BAND_B;
      cmru_pkg::S_BAND_B: begin
        state_nxt = inrng_r ? cmru_pkg::S_MUL : cmru_pkg::S_DRAIN;
      end
      cmru_pkg::S_MUL: begin
        if (mul_done) state_nxt = cmru_pkg::S_SQRT;
      end
      cmru_pkg::S_SQRT: begin
        if (sq_done) state_nxt = cmru_pkg::S_EDGE;
      end
      cmru_pkg::S_EDGE: begin
        if (!match_c && run_open_r) state_nxt = cmru_pkg::S_FLUSH_L;
        else                        state_nxt = cmru_pkg::S_END;
      end
      cmru_pkg::S_FLUSH_L: state_nxt = cmru_pkg::S_FLUSH_R;
      cmru_pkg::S_FLUSH_R: begin
        state_nxt = fin_r ? cmru_pkg::S_DRAIN : cmru_pkg::S_END;
      end
      cmru_pkg::S_END: begin
        state_nxt = is_last_row ? cmru_pkg::S_FLUSH_L : cmru_pkg::S_DRAIN;
      end
      cmru_pkg::S_DRAIN: begin
        if (buf_empty) state_nxt = cmru_pkg::S_IDLE;
      end
      default: state_nxt = cmru_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs
  // --------------------------------------------------------------------------
  always_comb begin
    ctl       = '0;
    mul_start = 1'b0;
    case (state_r)
      cmru_pkg::S_SETUP: begin
        // Closed circle: one full-screen rectangle at the start of the frame.
        ctl.push = rad_zero && row0;
        ctl.rect = mk_rect('0, '0, SCR_W, SCR_H);
      end
      cmru_pkg::S_BAND_T: begin
        ctl.push = row0 && (top_r != '0);
        ctl.rect = mk_rect('0, '0, SCR_W, top_r);
      end
      cmru_pkg::S_BAND_B: begin
        ctl.push  = row0 && (bot_r < SCR_H);
        ctl.rect  = mk_rect('0, bot_r, SCR_W, SCR_H);
        mul_start = inrng_r;
      end
      cmru_pkg::S_FLUSH_L: begin
        ctl.push = (run_left_r != '0);
        ctl.rect = mk_rect('0, CW'(run_start_r), run_left_r, fbot);
      end
      cmru_pkg::S_FLUSH_R: begin
        ctl.push = (run_right_r < SCR_W);
        ctl.rect = mk_rect(run_right_r, CW'(run_start_r), SCR_W, fbot);
      end
      cmru_pkg::S_DRAIN: begin
        ctl.drain = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign in_ch.ready  = (state_r == cmru_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cmru_pkg::S_IDLE;
      run_open_r <= 1'b0;
      cx_r       <= cmru_pkg::CENTER_X_RST;
      cy_r       <= cmru_pkg::CENTER_Y_RST;
      rad_r      <= cmru_pkg::RADIUS_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          cmru_pkg::REG_CENTER_X: cx_r  <= $signed(cfg_ch.data[CX_W-1:0]);
          cmru_pkg::REG_CENTER_Y: cy_r  <= $signed(cfg_ch.data[CX_W-1:0]);
          cmru_pkg::REG_RADIUS:   rad_r <= cfg_ch.data[R_W-1:0];
          default: begin
          end
        endcase
      end

      case (state_r)
        cmru_pkg::S_SETUP: begin
          // A new frame drops whatever run was left open.
          if (row0) run_open_r <= 1'b0;
        end
        cmru_pkg::S_EDGE: begin
          if (!run_open_r) run_open_r <= 1'b1;
        end
        cmru_pkg::S_FLUSH_R: begin
          run_open_r <= !fin_r;
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) row_r <= in_ch.row;

    case (state_r)
      cmru_pkg::S_SETUP: begin
        top_r   <= top_c;
        bot_r   <= bot_c;
        inrng_r <= inrng_c;
        fin_r   <= 1'b0;
      end
      cmru_pkg::S_SQRT: begin
        if (sq_done) h_r <= sq_h;
      end
      cmru_pkg::S_EDGE: begin
        new_l_r <= lx_c;
        new_r_r <= rx_c;
        if (match_c) begin
          // Same edges as the run: extend it, saturating the row count.
          if (run_rows_r != 9'h1FF) run_rows_r <= run_rows_r + 9'd1;
        end else if (!run_open_r) begin
          run_start_r <= row_r;
          run_rows_r  <= 9'd1;
          run_left_r  <= lx_c;
          run_right_r <= rx_c;
        end
      end
      cmru_pkg::S_FLUSH_R: begin
        // After flushing a broken run, start the new one from this row.
        if (!fin_r) begin
          run_start_r <= row_r;
          run_rows_r  <= 9'd1;
          run_left_r  <= new_l_r;
          run_right_r <= new_r_r;
        end
      end
      cmru_pkg::S_END: begin
        if (is_last_row) fin_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CMRU_ASSERT_NOW(a_sqrt_ceil, clk, rst_n, sq_done, (26'(sq_h) * 26'(sq_h) >= 26'(mul_p)) && ((sq_h == '0) || (26'(sq_h - H_W'(1)) * 26'(sq_h - H_W'(1)) < 26'(mul_p))), "half-width is not the ceiling square root")
  `CMRU_ASSERT_NOW(a_run_order, clk, rst_n, run_open_r, run_left_r <= run_right_r, "open run has its left edge beyond its right edge")
  `CMRU_ASSERT_NEXT(a_batch_follow, clk, rst_n, out_ch.valid && out_ch.ready && !out_ch.last_of_batch, out_ch.valid, "rectangle batch broken before its last transaction")

endmodule

// ----- tb/circle_mask_rect_generator_unit_tb.sv -----
// Self-checking testbench for the circle mask rectangle generator top level
module circle_mask_rect_generator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_W      = cmru_pkg::ROW_W;
  localparam int X_W        = cmru_pkg::X_W;
  localparam int Y_W        = cmru_pkg::Y_W;
  localparam int CX_W       = cmru_pkg::CX_W;
  localparam int R_W        = cmru_pkg::R_W;
  localparam int CFG_IDX_W  = cmru_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = cmru_pkg::CFG_DATA_W;

  localparam int SCREEN_W      = 256;
  localparam int SCREEN_H      = 240;
  localparam int OPEN_R_Q4     = 2968;
  localparam int MAX_GAP       = 18;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 900000;
  localparam int RANDOM_ROWS   = 450;
  localparam int MAX_SHOWN     = 10;
  localparam int RUN_ROWS_MAX  = 511;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  // One rectangle as it leaves the block, with its end-of-row marker.
  typedef struct packed {
    logic [X_W-1:0] x_left;
    logic [Y_W-1:0] y_top;
    logic [X_W-1:0] x_right;
    logic [Y_W-1:0] y_bottom;
    logic           last_of_batch;
  } mask_rect_t;

  logic clk;
  logic rst_n;

  cmru_row_if  in_ch();
  cmru_rect_if out_ch();
  cmru_cfg_if  cfg_ch();

  circle_mask_rect_generator_unit #(
    .SCREEN_WIDTH  (SCREEN_W),
    .SCREEN_HEIGHT (SCREEN_H),
    .OPEN_RADIUS_Q4(OPEN_R_Q4)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Mirror of the block's registers and of the open run, at reset values.
  logic signed [CX_W-1:0] cx_q4     = cmru_pkg::CENTER_X_RST;
  logic signed [CX_W-1:0] cy_q4     = cmru_pkg::CENTER_Y_RST;
  logic [R_W-1:0]         radius_q4 = cmru_pkg::RADIUS_RST;
  logic                   run_open  = 1'b0;
  logic [ROW_W-1:0]       run_top   = '0;
  logic [8:0]             run_rows  = '0;
  logic [X_W-1:0]         run_left  = '0;
  logic [X_W-1:0]         run_right = X_W'(SCREEN_W);

  mask_rect_t expected_rects[$];
  int         errors = 0;
  int         cycles = 0;
  bit         calm   = 1'b0;  // set to run a stretch with no idling on either side

  // ---------------------------------------------------------------------------
  // Fixed-point helpers
  // ---------------------------------------------------------------------------
  function automatic int floor16(input int a);
    return a >>> 4;
  endfunction

  function automatic int ceil16(input int a);
    return -((-a) >>> 4);
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Smallest root whose square reaches v; v never exceeds 4095^2.
  function automatic int ceil_sqrt(input int v);
    int root;
    root = 0;
    for (int b = 12; b >= 0; b--) begin
      if ((root | (1 << b)) * (root | (1 << b)) <= v) root = root | (1 << b);
    end
    if (root * root < v) root++;
    return root;
  endfunction

  // Rows [top, bot) touch the circle; both are clamped to the screen.
  function automatic void band_limits(output int top, output int bot);
    top = clamp(floor16(int'(cy_q4) - int'(radius_q4)), 0, SCREEN_H);
    bot = clamp(ceil16(int'(cy_q4) + int'(radius_q4)), 0, SCREEN_H);
  endfunction

  // ---------------------------------------------------------------------------
  // Rectangle predictor
  // ---------------------------------------------------------------------------
  function automatic void add_rect(input int xl, input int yt, input int xr, input int yb);
    mask_rect_t r;
    r.x_left        = X_W'(xl);
    r.y_top         = Y_W'(yt);
    r.x_right       = X_W'(xr);
    r.y_bottom      = Y_W'(yb);
    r.last_of_batch = 1'b0;
    expected_rects.push_back(r);
  endfunction

  // Emit the left and right rectangles of the open run, skipping empty ones.
  function automatic void close_run();
    int bottom;
    bottom = clamp(int'(run_top) + int'(run_rows), 0, SCREEN_H);
    if (run_left > 0) add_rect(0, run_top, run_left, bottom);
    if (int'(run_right) < SCREEN_W) add_rect(run_right, run_top, SCREEN_W, bottom);
    run_open = 1'b0;
  endfunction

  function automatic void predict_rects(input logic [ROW_W-1:0] row_in);
    int         row, top, bot, dy, radicand, half, lx, rx, first;
    mask_rect_t tail;
    row   = int'(row_in);
    first = expected_rects.size();
    // Start of frame: drop whatever run was left open.
    if (row == 0) run_open = 1'b0;
    if (int'(radius_q4) >= OPEN_R_Q4) return;
    if (radius_q4 == '0) begin
      // Closed circle: one full-screen rectangle on row 0 only.
      if (row == 0) add_rect(0, 0, SCREEN_W, SCREEN_H);
    end else begin
      band_limits(top, bot);
      if (row == 0) begin
        if (top > 0) add_rect(0, 0, SCREEN_W, top);
        if (bot < SCREEN_H) add_rect(0, bot, SCREEN_W, SCREEN_H);
      end
      if (row >= top && row < bot) begin
        dy       = row * 16 + 8 - int'(cy_q4);
        radicand = int'(radius_q4) * int'(radius_q4) - dy * dy;
        if (radicand < 0) radicand = 0;
        half = ceil_sqrt(radicand);
        lx   = clamp(floor16(int'(cx_q4) - half), 0, SCREEN_W);
        rx   = clamp(ceil16(int'(cx_q4) + half), 0, SCREEN_W);
        if (run_open && lx == int'(run_left) && rx == int'(run_right)) begin
          if (run_rows < RUN_ROWS_MAX) run_rows++;
        end else begin
          if (run_open) close_run();
          run_open  = 1'b1;
          run_top   = ROW_W'(row);
          run_rows  = 9'd1;
          run_left  = X_W'(lx);
          run_right = X_W'(rx);
        end
        // Last row inside the circle: flush the run.
        if (row == bot - 1) close_run();
      end
    end
    if (expected_rects.size() > first) begin
      tail = expected_rects.pop_back();
      tail.last_of_batch = 1'b1;
      expected_rects.push_back(tail);
    end
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    case (idx)
      cmru_pkg::REG_CENTER_X: cx_q4 = value;
      cmru_pkg::REG_CENTER_Y: cy_q4 = value;
      cmru_pkg::REG_RADIUS: radius_q4 = value[R_W-1:0];
      default: ;
    endcase
  endfunction

  // Compare one rectangle transaction with the oldest expectation.
  function automatic void check_rect();
    mask_rect_t got, want;
    got.x_left        = out_ch.x_left;
    got.y_top         = out_ch.y_top;
    got.x_right       = out_ch.x_right;
    got.y_bottom      = out_ch.y_bottom;
    got.last_of_batch = out_ch.last_of_batch;
    if (expected_rects.size() == 0) begin
      errors++;
      if (errors <= MAX_SHOWN)
        $display("unexpected rect: xl=%0d yt=%0d xr=%0d yb=%0d last=%0b",
                 got.x_left, got.y_top, got.x_right, got.y_bottom, got.last_of_batch);
    end else begin
      want = expected_rects.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("rect mismatch: exp xl=%0d yt=%0d xr=%0d yb=%0d last=%0b, got xl=%0d yt=%0d xr=%0d yb=%0d last=%0b",
                   want.x_left, want.y_top, want.x_right, want.y_bottom, want.last_of_batch,
                   got.x_left, got.y_top, got.x_right, got.y_bottom, got.last_of_batch);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit and monitor
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Sample every channel at the edge: check results first, then predict.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_rect();
      if (in_ch.valid && in_ch.ready) predict_rects(in_ch.row);
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
    end
  end

  // Idle for a random number of cycles, or not at all during a calm stretch.
  function automatic int draw_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // Result side: hold ready low for a fresh gap before every transaction.
  initial begin : rect_sink
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Send one row; valid stays high on return so the next row can follow
  // back to back. Anything that waits afterwards lowers it first.
  task automatic send_row(input int row);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.row   <= ROW_W'(row);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every expected rectangle, then let a silent row finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    // Let the monitor apply the write before anyone plans from it.
    @(posedge clk);
  endtask

  task automatic set_circle(input int cx, input int cy, input int r);
    settle();
    write_reg(cmru_pkg::REG_CENTER_X, cx);
    write_reg(cmru_pkg::REG_CENTER_Y, cy);
    write_reg(cmru_pkg::REG_RADIUS, r);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset registers give the open radius: nothing comes out.
  task automatic test_open_default();
    settle();
    send_row(0);
    send_row(200);
  endtask

  // Radius 0 gives one full-screen rectangle; junk above bit 11 is dropped.
  task automatic test_closed_circle();
    set_circle(128 * 16, 120 * 16, 3 << R_W);
    send_row(0);
    send_row(120);
  endtask

  // Small centered circle: both bands, merged runs, flush at its last row.
  task automatic test_small_circle();
    int top, bot;
    set_circle(128 * 16 + 8, 120 * 16, 40);
    band_limits(top, bot);
    send_row(0);
    for (int row = top; row < bot; row++) send_row(row);
  endtask

  // Circle far off screen on both sides, largest radius below open, and above.
  task automatic test_off_screen();
    set_circle(-8192, 8191, OPEN_R_Q4 - 1);
    send_row(0);
    set_circle(8191, -8192, 1);
    write_reg(REG_SPARE, 16383);
    send_row(0);
    set_circle(0, 0, 4095);
    send_row(0);
  endtask

  // Rows off screen, out of order, repeated, and a restart of the frame.
  task automatic test_row_disorder();
    int top, bot;
    set_circle(0, 60 * 16, 200);
    band_limits(top, bot);
    send_row(0);
    send_row(255);
    send_row(top + 3);
    send_row(top + 1);
    send_row(top + 1);
    send_row(0);
    send_row(bot - 1);
  endtask

  // Radius changes while a run is open: the run keeps its stored edges.
  task automatic test_mid_frame_config();
    int top, bot;
    set_circle(128 * 16, 120 * 16, 96);
    band_limits(top, bot);
    send_row(0);
    send_row(top);
    settle();
    write_reg(cmru_pkg::REG_RADIUS, 160);
    band_limits(top, bot);
    send_row(top + 2);
    send_row(bot - 1);
  endtask

  // One frame of the current circle: row 0, then the rows around the circle
  // in order, with stray rows mixed in and an odd row skipped.
  task automatic run_frame(output int counted);
    int top, bot, row;
    band_limits(top, bot);
    counted = 1;
    send_row(0);
    row = (top > 1) ? top - 1 : 1;
    while (row <= bot && row < 256) begin
      if ($urandom_range(0, 19) == 0) begin
        send_row($urandom_range(0, 255));
        counted++;
      end
      if ($urandom_range(0, 29) != 0) begin
        send_row(row);
        counted++;
      end
      row++;
    end
  endtask

  task automatic test_random_frames();
    int counted, sent, pick, cx, cy, r;
    counted = 0;
    while (counted < RANDOM_ROWS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) r = $urandom_range(1, 320);
      else if (pick < 82) r = $urandom_range(321, 1600);
      else if (pick < 88) r = 0;
      else if (pick < 93) r = $urandom_range(OPEN_R_Q4, 4095);
      else r = $urandom_range(1, 15);
      if ($urandom_range(0, 5) == 0) begin
        cx = $urandom_range(0, 16383) - 8192;
        cy = $urandom_range(0, 16383) - 8192;
      end else begin
        cx = $urandom_range(0, 4608) - 256;
        cy = $urandom_range(0, 4352) - 256;
      end
      // Hold the old registers while the last frame drains.
      set_circle(cx, cy, r | ($urandom_range(0, 3) << R_W));
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, $urandom_range(0, 16383));
      calm = ($urandom_range(0, 3) == 0);
      run_frame(sent);
      counted += sent;
    end
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.row    = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = cmru_pkg::REG_CENTER_X;
    cfg_ch.data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_open_default();
    test_closed_circle();
    test_small_circle();
    test_off_screen();
    test_row_disorder();
    test_mid_frame_config();
    test_random_frames();

    // Drain, then watch a while longer for stray rectangles.
    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cmru_pkg.sv
rtl/cmru_channels.sv
rtl/cmru_ser_mult.sv
rtl/cmru_ser_sqrt.sv
rtl/cmru_rect_buf.sv
rtl/circle_mask_rect_generator_unit.sv
tb/circle_mask_rect_generator_unit_tb.sv
